// ----- sv/assert_macros.svh -----
// Assertion macros shared by the splitter RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JTAS_ASSERT_IMP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JTAS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JTAS_ASSERT_IMP(label, clk, rst_n, prop, msg)
`define JTAS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- sv/jtas_pkg.sv -----
// Types, constants and key tables for the tracks array object splitter.
// Depends on nothing.
package jtas_pkg;

    localparam int DEPTH_BITS = 8;
    localparam int KEY_LEN    = 8;
    localparam int POS_BITS   = $clog2(KEY_LEN);

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_SEEK_RESULT  = 3'd0,
        PH_WAIT_BRACE   = 3'd1,
        PH_SEEK_TRACKS  = 3'd2,
        PH_WAIT_BRACKET = 3'd3,
        PH_IN_ARRAY     = 3'd4,
        PH_CAPTURE      = 3'd5
    } t_phase;

    typedef enum logic {
        KEY_RESULT = 1'b0,
        KEY_TRACKS = 1'b1
    } t_key_sel;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       start;
        logic       last;
        logic       err;
    } t_step_res;

    function automatic logic [7:0] key_char(input t_key_sel sel,
                                            input logic [POS_BITS-1:0] pos);
        logic [7:0] ch;
        ch = CH_QUOTE;
        case (pos)
            3'd1: ch = (sel == KEY_TRACKS) ? 8'h74 : 8'h72;
            3'd2: ch = (sel == KEY_TRACKS) ? 8'h72 : 8'h65;
            3'd3: ch = (sel == KEY_TRACKS) ? 8'h61 : 8'h73;
            3'd4: ch = (sel == KEY_TRACKS) ? 8'h63 : 8'h75;
            3'd5: ch = (sel == KEY_TRACKS) ? 8'h6B : 8'h6C;
            3'd6: ch = (sel == KEY_TRACKS) ? 8'h73 : 8'h74;
            default: ch = CH_QUOTE;
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/jtas_key_match.sv -----
// Next-position logic for one quoted key matcher with the simple restart rule.
// Depends on jtas_pkg.
module jtas_key_match
    import jtas_pkg::*;
(
    input  t_key_sel            i_sel,
    input  logic [POS_BITS-1:0] i_pos,
    input  logic [7:0]          i_byte,
    output logic [POS_BITS-1:0] o_pos,
    output logic                o_done
);

    always_comb begin
        o_done = 1'b0;
        if (i_byte == key_char(i_sel, i_pos)) begin
            if (i_pos == POS_BITS'(KEY_LEN - 1)) begin
                o_pos  = '0;
                o_done = 1'b1;
            end else begin
                o_pos = i_pos + POS_BITS'(1);
            end
        end else if (i_byte == CH_QUOTE) begin
            o_pos = POS_BITS'(1);
        end else begin
            o_pos = '0;
        end
    end

endmodule

// ----- sv/jtas_step.sv -----
// Parser state and the per-word step logic of the splitter.
// Depends on jtas_pkg and jtas_key_match.
module jtas_step
    import jtas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_step_res  o_res
);

    t_phase                r_phase, n_phase;
    logic [POS_BITS-1:0]   r_res_pos, n_res_pos;
    logic [POS_BITS-1:0]   r_trk_pos, n_trk_pos;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic                  r_in_str, n_in_str;
    logic                  r_esc, n_esc;

    logic [POS_BITS-1:0]   res_pos_next, trk_pos_next;
    logic                  res_done, trk_done;
    logic [DEPTH_BITS-1:0] depth_dec;

    jtas_key_match u_res_match (
        .i_sel  (KEY_RESULT),
        .i_pos  (r_res_pos),
        .i_byte (i_byte),
        .o_pos  (res_pos_next),
        .o_done (res_done)
    );

    jtas_key_match u_trk_match (
        .i_sel  (KEY_TRACKS),
        .i_pos  (r_trk_pos),
        .i_byte (i_byte),
        .o_pos  (trk_pos_next),
        .o_done (trk_done)
    );

    assign depth_dec = (r_depth != '0) ? r_depth - DEPTH_BITS'(1) : r_depth;

    always_comb begin
        n_phase   = r_phase;
        n_res_pos = r_res_pos;
        n_trk_pos = r_trk_pos;
        n_depth   = r_depth;
        n_in_str  = r_in_str;
        n_esc     = r_esc;
        case (r_phase)
            PH_WAIT_BRACE: begin
                if (i_byte == CH_LBRACE) begin
                    n_phase = PH_SEEK_TRACKS;
                end
            end
            PH_SEEK_TRACKS: begin
                n_trk_pos = trk_pos_next;
                if (trk_done) begin
                    n_phase = PH_WAIT_BRACKET;
                end
            end
            PH_WAIT_BRACKET: begin
                if (i_byte == CH_LBRACK) begin
                    n_phase = PH_IN_ARRAY;
                end
            end
            PH_IN_ARRAY: begin
                if (i_byte == CH_RBRACK) begin
                    n_phase = PH_SEEK_TRACKS;
                end else if (i_byte == CH_LBRACE) begin
                    n_phase  = PH_CAPTURE;
                    n_depth  = DEPTH_BITS'(1);
                    n_in_str = 1'b0;
                    n_esc    = 1'b0;
                end
            end
            PH_CAPTURE: begin
                if (r_in_str) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (i_byte == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (i_byte == CH_QUOTE) begin
                        n_in_str = 1'b0;
                    end
                end else if (i_byte == CH_QUOTE) begin
                    n_in_str = 1'b1;
                end else if (i_byte == CH_LBRACE) begin
                    if (r_depth != DEPTH_MAX) begin
                        n_depth = r_depth + DEPTH_BITS'(1);
                    end
                end else if (i_byte == CH_RBRACE) begin
                    n_depth = depth_dec;
                    if (depth_dec == '0) begin
                        n_phase  = PH_IN_ARRAY;
                        n_in_str = 1'b0;
                        n_esc    = 1'b0;
                    end
                end
            end
            default: begin
                n_res_pos = res_pos_next;
                n_phase   = res_done ? PH_WAIT_BRACE : PH_SEEK_RESULT;
            end
        endcase
    end

    always_comb begin
        o_res.data  = i_byte;
        o_res.valid = 1'b0;
        o_res.start = 1'b0;
        o_res.last  = 1'b0;
        o_res.err   = 1'b0;
        case (r_phase)
            PH_IN_ARRAY: begin
                if (i_byte == CH_LBRACE) begin
                    o_res.valid = 1'b1;
                    o_res.start = 1'b1;
                end
            end
            PH_CAPTURE: begin
                o_res.valid = 1'b1;
                if (!r_in_str) begin
                    o_res.err  = (i_byte == CH_LBRACE) && (r_depth == DEPTH_MAX);
                    o_res.last = (i_byte == CH_RBRACE) && (depth_dec == '0);
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK_RESULT;
            r_res_pos <= '0;
            r_trk_pos <= '0;
            r_depth   <= '0;
            r_in_str  <= 1'b0;
            r_esc     <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_res_pos <= n_res_pos;
            r_trk_pos <= n_trk_pos;
            r_depth   <= n_depth;
            r_in_str  <= n_in_str;
            r_esc     <= n_esc;
        end
    end

endmodule

// ----- sv/json_tracks_array_object_splitter.sv -----
// Top level of the tracks array object splitter: input and result registers.
// Depends on jtas_pkg, jtas_step and assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   input   | in        | i_valid / o_stall   | i_data_byte
//   result  | out       | o_valid / i_stall   | o_object_byte, o_object_start,
//           |           |                     | o_object_end, o_depth_error
//
// One word is taken per cycle while o_stall is low; a word waits in the input register
// and its result, if any, is written to the result register when the word leaves it.
// The parser state advances once per word, which sets the rate of one per cycle unless the result side stalls.
// Reset is synchronous and active low and returns the parser to the result key search.
// A stall on the result side holds the result register and, once the input
// register is also full, raises o_stall.
`include "assert_macros.svh"

module json_tracks_array_object_splitter
    import jtas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_object_byte,
    output logic       o_object_start,
    output logic       o_object_end,
    output logic       o_depth_error
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_step_res  r_out;
    t_step_res  step_res;
    logic       out_free, fire, accept;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !fire;
    assign accept   = i_valid && !o_stall;

    jtas_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = fire ? step_res.valid : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
        end
        if (fire && step_res.valid) begin
            r_out <= step_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_object_byte  = r_out.data;
    assign o_object_start = r_out.start;
    assign o_object_end   = r_out.last;
    assign o_depth_error  = r_out.err;

    `JTAS_ASSERT_IMP(a_start_brace, i_clk, i_rst_n, o_valid && o_object_start |-> o_object_byte == CH_LBRACE, "start mark on a byte other than an opening brace")
    `JTAS_ASSERT_IMP(a_end_brace, i_clk, i_rst_n, o_valid && o_object_end |-> o_object_byte == CH_RBRACE, "end mark on a byte other than a closing brace")
    `JTAS_ASSERT_IMP(a_err_brace, i_clk, i_rst_n, o_valid && o_depth_error |-> o_object_byte == CH_LBRACE && !o_object_start, "depth error on a byte that cannot nest")
    `JTAS_ASSERT_NEVER(a_stall_empty, i_clk, i_rst_n, o_stall && !r_in_valid, "input stalled while the input register is empty")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for json_tracks_array_object_splitter: feeds JSON text and
// checks every framed object word against a built-in prediction of the splitter.
// Depends on jtas_pkg and the splitter RTL.
module testbench
    import jtas_pkg::*;
();

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BYTES = 450;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       overflow;
    } t_framed_byte;

    class object_frame_tracker;
        t_phase                phase;
        int                    result_pos;
        int                    tracks_pos;
        logic [DEPTH_BITS-1:0] depth;
        bit                    str_open;
        bit                    escaped;
        t_framed_byte          framed_q[$];
        string                 key_res_text = "\"result\"";
        string                 key_trk_text = "\"tracks\"";
        int                    errors;
        int                    bytes_checked;
        int                    objects_closed;
        int                    overflows;

        function new();
            phase = PH_SEEK_RESULT;
            result_pos = 0;
            tracks_pos = 0;
            depth = '0;
            str_open = 1'b0;
            escaped = 1'b0;
            errors = 0;
            bytes_checked = 0;
            objects_closed = 0;
            overflows = 0;
        endfunction

        function bit key_step(string key, inout int pos, input logic [7:0] c);
            int p;
            p = pos & 7;
            if (c == key[p]) begin
                p++;
                if (p >= KEY_LEN) begin
                    pos = 0;
                    return 1'b1;
                end
                pos = p;
            end else begin
                pos = (c == CH_QUOTE) ? 1 : 0;
            end
            return 1'b0;
        endfunction

        function void take_input_byte(logic [7:0] c);
            t_framed_byte res;
            bit emit;
            emit = 1'b0;
            res = '{data: c, first: 1'b0, last: 1'b0, overflow: 1'b0};
            case (phase)
                PH_WAIT_BRACE: begin
                    if (c == CH_LBRACE) phase = PH_SEEK_TRACKS;
                end
                PH_SEEK_TRACKS: begin
                    if (key_step(key_trk_text, tracks_pos, c)) phase = PH_WAIT_BRACKET;
                end
                PH_WAIT_BRACKET: begin
                    if (c == CH_LBRACK) phase = PH_IN_ARRAY;
                end
                PH_IN_ARRAY: begin
                    if (c == CH_RBRACK) begin
                        phase = PH_SEEK_TRACKS;
                    end else if (c == CH_LBRACE) begin
                        phase = PH_CAPTURE;
                        depth = DEPTH_BITS'(1);
                        str_open = 1'b0;
                        escaped = 1'b0;
                        res.first = 1'b1;
                        emit = 1'b1;
                    end
                end
                PH_CAPTURE: begin
                    emit = 1'b1;
                    if (str_open) begin
                        if (escaped) begin
                            escaped = 1'b0;
                        end else if (c == CH_BSLASH) begin
                            escaped = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            str_open = 1'b0;
                        end
                    end else if (c == CH_QUOTE) begin
                        str_open = 1'b1;
                    end else if (c == CH_LBRACE) begin
                        if (depth == DEPTH_MAX) begin
                            res.overflow = 1'b1;
                        end else begin
                            depth++;
                        end
                    end else if (c == CH_RBRACE) begin
                        if (depth != 0) depth--;
                        if (depth == 0) begin
                            res.last = 1'b1;
                            phase = PH_IN_ARRAY;
                            str_open = 1'b0;
                            escaped = 1'b0;
                        end
                    end
                end
                default: begin
                    phase = PH_SEEK_RESULT;
                    if (key_step(key_res_text, result_pos, c)) phase = PH_WAIT_BRACE;
                end
            endcase
            if (emit) framed_q.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_framed_byte(logic [7:0] data, logic first, logic last,
                                        logic overflow);
            t_framed_byte want;
            if (framed_q.size() == 0) begin
                $error("object_byte: expected no word, got 'h%0h", data);
                errors++;
                return;
            end
            want = framed_q.pop_front();
            compare_field("object_byte", want.data, data);
            compare_field("object_start", want.first, first);
            compare_field("object_end", want.last, last);
            compare_field("depth_error", want.overflow, overflow);
            bytes_checked++;
            if (want.last) objects_closed++;
            if (want.overflow) overflows++;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_object_byte;
    logic       o_object_start;
    logic       o_object_end;
    logic       o_depth_error;

    object_frame_tracker tracker = new();
    logic [7:0] text_q[$];
    int         bytes_fed = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;

    json_tracks_array_object_splitter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_object_byte  (o_object_byte),
        .o_object_start (o_object_start),
        .o_object_end   (o_object_end),
        .o_depth_error  (o_depth_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void put_json_string();
        string plain;
        int n;
        plain = "abz019 :,{}[]_-";
        text_q.push_back(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_q.push_back(plain[$urandom_range(0, plain.len() - 1)]);
            end
        end
        text_q.push_back(CH_QUOTE);
    endfunction

    function automatic void put_value(int lvl);
        case ($urandom_range(0, (lvl < 3) ? 4 : 1))
            0: put_str($sformatf("%0d", $urandom_range(0, 99999)));
            1: put_json_string();
            2, 3: put_object(lvl + 1);
            default: put_array(lvl + 1);
        endcase
    endfunction

    function automatic void put_object(int lvl);
        int n;
        text_q.push_back(CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if (i != 0) put_str(",");
            put_json_string();
            put_str(":");
            put_value(lvl);
        end
        text_q.push_back(CH_RBRACE);
    endfunction

    function automatic void put_array(int lvl);
        int n;
        text_q.push_back(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if (i != 0) put_str(",");
            put_value(lvl);
        end
        text_q.push_back(CH_RBRACK);
    endfunction

    function automatic void put_noise(int n);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_tracks_section();
        int n;
        if ($urandom_range(0, 1) != 0) put_str("\"id\":7,");
        put_str("\"tracks\":[");
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i != 0) put_str(", ");
            put_object(0);
        end
        put_str("]");
        if ($urandom_range(0, 2) == 0) put_str("}");
    endfunction

    function automatic void put_broken_section();
        case ($urandom_range(0, 3))
            0: put_str("\"trac\"\"tracks\" x [ q {\"b\":[]}, ] ");
            1: begin
                put_str("\"tracks\":[{\"x\":{");
                put_noise($urandom_range(1, 6));
                put_str("\"}}]");
            end
            2: put_noise($urandom_range(1, 6));
            default: put_str("\"tracks\"[ ] } \"result\":{ ]");
        endcase
    endfunction

    function automatic void build_text();
        int base;
        // Opening: key restart on a quote, ignored bytes, an escaped quote and
        // braces inside a string, byte extremes.
        put_str("\"result\"{\"\"tracks\"[");
        text_q.push_back(8'h00);
        put_str("{\"\\\"}");
        text_q.push_back(8'hFF);
        put_str("\"}]");
        // Nesting past the counter range, then back down to the outer brace.
        put_str("\"tracks\":[");
        repeat (DEPTH_MAX + 2) text_q.push_back(CH_LBRACE);
        repeat (DEPTH_MAX) text_q.push_back(CH_RBRACE);
        put_str("]");
        base = text_q.size();
        while (text_q.size() - base < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 78) begin
                put_tracks_section();
            end else begin
                put_broken_section();
            end
        end
    endfunction

    task automatic feed_text();
        bit holding;
        holding = 1'b0;
        while (bytes_fed < text_q.size()) begin
            @(negedge i_clk);
            if (!holding) begin
                if (!calm && $urandom_range(0, 99) < 33) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_data_byte <= text_q[bytes_fed];
                end
            end
            @(posedge i_clk);
            holding = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                tracker.take_input_byte(i_data_byte);
                bytes_fed++;
                calm = (bytes_fed >= 700 && bytes_fed < 950);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            tracker.check_framed_byte(o_object_byte, o_object_start, o_object_end,
                                      o_depth_error);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("json_tracks_array_object_splitter: mismatch");
            $finish;
        end
    end

    initial begin
        build_text();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        feed_text();
        while (tracker.framed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Fed %0d text bytes; checked %0d object words in %0d closed objects,",
                 bytes_fed, tracker.bytes_checked, tracker.objects_closed);
        $display("including %0d words with the depth counter held at its limit.",
                 tracker.overflows);
        if (tracker.errors == 0) begin
            $display("json_tracks_array_object_splitter: match");
        end else begin
            $display("json_tracks_array_object_splitter: mismatch");
        end
        $finish;
    end
endmodule
